// File: rtl/ldd_pkg.sv
package ldd_pkg;

  localparam int LANES     = 28;
  localparam int MAX_DELAY = 128;
  localparam int NUM_WORDS = 4;

  localparam int CFG_W     = 64;
  localparam int CIDX_W    = 2;
  localparam int DATUM_W   = 8;
  localparam int DLY_W     = 8;
  localparam int LANE_W    = 5;
  localparam int ELEM_W    = DATUM_W + 2;
  localparam int FC_W      = 8;

  localparam int LIDX_W    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PTR_W     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DEPTH     = LANES * MAX_DELAY;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [FC_W-1:0] FC_MAX = {FC_W{1'b1}};

  typedef enum logic {
    FUNC_PUSH  = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

  typedef struct packed {
    logic [NUM_WORDS-1:0][CFG_W-1:0] words;
    logic [DLY_W-1:0]                max_dly;
  } dly_cfg_t;

  function automatic logic [DLY_W-1:0] clamp_dly(logic [DLY_W-1:0] raw);
    logic [DLY_W-1:0] lim;
    lim = DLY_W'(MAX_DELAY);
    return (raw > lim) ? lim : raw;
  endfunction

endpackage

// File: rtl/ldd_intf.sv
interface ldd_in_if import ldd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [DATUM_W-1:0] datum;
  logic               error_flag;
  logic               padded_flag;

  modport source (output valid, func, datum, error_flag, padded_flag, input ready);
  modport sink   (input valid, func, datum, error_flag, padded_flag, output ready);
endinterface

interface ldd_out_if import ldd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATUM_W-1:0] out_datum;
  logic               out_error;
  logic               out_padded;
  logic [LANE_W-1:0]  lane_index;
  logic               frame_end;

  modport source (output valid, out_datum, out_error, out_padded, lane_index, frame_end,
                  input ready);
  modport sink   (input valid, out_datum, out_error, out_padded, lane_index, frame_end,
                  output ready);
endinterface

interface ldd_cfg_if import ldd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ldd_ram.sv
module ldd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ldd_cfg.sv
module ldd_cfg import ldd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ldd_cfg_if.sink  cfg_i,
  output dly_cfg_t cfg_o
);

  logic [NUM_WORDS-1:0][CFG_W-1:0] words_q;
  logic [DLY_W-1:0]                wmax_q [NUM_WORDS];
  logic [DLY_W-1:0]                wmax_d;
  logic [DLY_W-1:0]                max_q;
  logic [DLY_W-1:0]                max_d;
  logic                            wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  // max over the lanes carried by the word being written, unused lanes ignored
  always_comb begin
    logic [LANE_W-1:0] lane;
    logic [DLY_W-1:0]  c;
    wmax_d = '0;
    for (int j = 0; j < 8; j++) begin
      lane = {cfg_i.index, 3'(j)};
      c    = clamp_dly(cfg_i.data[j*8 +: 8]);
      if ((LANE_W + 1)'(lane) < (LANE_W + 1)'(LANES) && c > wmax_d) begin
        wmax_d = c;
      end
    end
  end

  always_comb begin
    max_d = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (wmax_q[w] > max_d) begin
        max_d = wmax_q[w];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
      max_q   <= '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        wmax_q[w] <= '0;
      end
    end else begin
      max_q <= max_d;
      if (wr) begin
        words_q[cfg_i.index] <= cfg_i.data;
        wmax_q[cfg_i.index]  <= wmax_d;
      end
    end
  end

  assign cfg_o.words   = words_q;
  assign cfg_o.max_dly = max_q;

endmodule

// File: rtl/lane_delay_deinterleaver.sv
// lane delay deinterleaver
// in_i carries one lane element per beat (byte, error and padded flags); the
// lane position is counted internally and wraps after the last lane of a frame.
// a flush beat clears the lane pointers, lane position and frame count and
// gives no result. out_o carries the delayed element with its lane index and
// a frame end mark on the last lane. cfg_i writes the four delay words, one
// byte per lane, and is always ready; delays above the maximum are clamped.
// every lane owns a ring in one shared store: each element on a lane with a
// nonzero delay reads its slot and writes the new element to the same slot in
// the same cycle. an input beat is registered in stage 1, where its store data
// arrives, then in the output register. throughput: one element per cycle
// unless stalled, set by the single store access per beat. no result is given
// until the frame count reaches the largest lane delay. reset clears pointers,
// counters and delays; the store is not cleared and needs no clearing pass.
// when the receiver stalls, the output register and one pipeline stage hold
// their beats and in_i.ready drops once both are full.
module lane_delay_deinterleaver import ldd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ldd_cfg_if.sink   cfg_i,
  ldd_in_if.sink    in_i,
  ldd_out_if.source out_o
);

  dly_cfg_t cfg;

  logic [LIDX_W-1:0] lane_pos_q;
  logic [PTR_W-1:0]  ptr_q [LANES];
  logic [FC_W-1:0]   fc_q;

  logic [LANE_W-1:0] lane5;
  logic [DLY_W-1:0]  dly;
  logic [PTR_W-1:0]  p_cur;
  logic [PTR_W-1:0]  p_use;
  logic [DLY_W-1:0]  p_inc;
  logic [PTR_W-1:0]  p_next;
  logic [ADDR_W-1:0] addr;
  logic [ELEM_W-1:0] elem;
  logic [ELEM_W-1:0] rdata;
  logic              last;
  logic              accept;
  logic              push;
  logic              flush;
  logic              mem_en;

  logic              s1_valid_q;
  logic              s1_valid_d;
  logic [ELEM_W-1:0] s1_elem_q;
  logic              s1_bypass_q;
  logic [LIDX_W-1:0] s1_lane_q;
  logic              s1_last_q;
  logic [FC_W-1:0]   s1_fc_q;
  logic              s1_emit;
  logic              s1_adv;
  logic [ELEM_W-1:0] s1_res;

  logic              o_valid_q;
  logic [ELEM_W-1:0] o_elem_q;
  logic [LANE_W-1:0] o_lane_q;
  logic              o_last_q;

  ldd_cfg u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cfg_o (cfg)
  );

  assign accept = in_i.valid & in_i.ready;
  assign push   = accept & (func_e'(in_i.func) == FUNC_PUSH);
  assign flush  = accept & (func_e'(in_i.func) == FUNC_FLUSH);

  assign lane5  = LANE_W'(lane_pos_q);
  assign dly    = clamp_dly(cfg.words[lane5[4:3]][{lane5[2:0], 3'b000} +: 8]);
  assign p_cur  = ptr_q[lane_pos_q];
  assign p_use  = (DLY_W'(p_cur) >= dly) ? '0 : p_cur;
  assign p_inc  = DLY_W'(p_use) + DLY_W'(1);
  assign p_next = (p_inc >= dly) ? '0 : PTR_W'(p_inc);
  assign addr   = ADDR_W'(lane_pos_q) * ADDR_W'(MAX_DELAY) + ADDR_W'(p_use);
  assign elem   = {in_i.padded_flag, in_i.error_flag, in_i.datum};
  assign last   = (lane_pos_q == LIDX_W'(LANES - 1));
  assign mem_en = push & (dly != '0);

  ldd_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_en),
    .waddr_i(addr),
    .wdata_i(elem),
    .re_i   (mem_en),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_pos_q <= '0;
      fc_q       <= '0;
      for (int i = 0; i < LANES; i++) begin
        ptr_q[i] <= '0;
      end
    end else if (flush) begin
      lane_pos_q <= '0;
      fc_q       <= '0;
      for (int i = 0; i < LANES; i++) begin
        ptr_q[i] <= '0;
      end
    end else if (push) begin
      if (dly != '0) begin
        ptr_q[lane_pos_q] <= p_next;
      end
      if (last) begin
        lane_pos_q <= '0;
        if (fc_q != FC_MAX) begin
          fc_q <= fc_q + FC_W'(1);
        end
      end else begin
        lane_pos_q <= lane_pos_q + LIDX_W'(1);
      end
    end
  end

  // stage 1: store data arrives, emit decision against the largest delay
  assign s1_emit = (s1_fc_q >= cfg.max_dly);
  assign s1_res  = s1_bypass_q ? s1_elem_q : rdata;
  assign s1_adv  = s1_valid_q & (~s1_emit | ~o_valid_q | out_o.ready);
  assign in_i.ready = ~s1_valid_q | s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (push) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      s1_elem_q   <= elem;
      s1_bypass_q <= (dly == '0);
      s1_lane_q   <= lane_pos_q;
      s1_last_q   <= last;
      s1_fc_q     <= fc_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (s1_adv & s1_emit) begin
      o_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv & s1_emit) begin
      o_elem_q <= s1_res;
      o_lane_q <= LANE_W'(s1_lane_q);
      o_last_q <= s1_last_q;
    end
  end

  assign out_o.valid      = o_valid_q;
  assign out_o.out_datum  = o_elem_q[DATUM_W-1:0];
  assign out_o.out_error  = o_elem_q[DATUM_W];
  assign out_o.out_padded = o_elem_q[DATUM_W+1];
  assign out_o.lane_index = o_lane_q;
  assign out_o.frame_end  = o_last_q;

endmodule

// File: rtl/ldd_chk.sv
module ldd_chk import ldd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DATUM_W-1:0] out_datum,
  input logic [LANE_W-1:0]  lane_index,
  input logic               frame_end
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_datum) && $stable(lane_index))
    else $error("output beat changed while stalled");

  a_lane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (LANE_W + 1)'(lane_index) < (LANE_W + 1)'(LANES))
    else $error("lane index out of range");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> frame_end == (lane_index == LANE_W'(LANES - 1)))
    else $error("frame end does not match last lane");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind lane_delay_deinterleaver ldd_chk u_ldd_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_datum (out_o.out_datum),
  .lane_index(out_o.lane_index),
  .frame_end (out_o.frame_end)
);
